FILE: rtl/rfid_whitelist_lookup_learn_macros.svh
// Assertion macros for the RFID whitelist block checker.
`ifndef RFID_WHITELIST_LOOKUP_LEARN_MACROS_SVH
`define RFID_WHITELIST_LOOKUP_LEARN_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RWL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rwl_pkg.sv
// Shared codes and field widths of the RFID whitelist block.
`default_nettype none

package rwl_pkg;

  // Fixed field widths
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned OUTCOME_W = 4;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_TAG     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TIMER   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BUS_ADD = 2'd2;

  // Operating modes; the spare code acts as remote mode
  localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUTTON = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADMIN  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // Result outcomes
  localparam logic [OUTCOME_W-1:0] OC_KNOWN          = 4'd0;
  localparam logic [OUTCOME_W-1:0] OC_WINDOW         = 4'd1;
  localparam logic [OUTCOME_W-1:0] OC_LEARNED        = 4'd2;
  localparam logic [OUTCOME_W-1:0] OC_EMPTY_PASS     = 4'd3;
  localparam logic [OUTCOME_W-1:0] OC_DENIED         = 4'd4;
  localparam logic [OUTCOME_W-1:0] OC_ADMIN_REPLACED = 4'd5;
  localparam logic [OUTCOME_W-1:0] OC_ADDED          = 4'd6;
  localparam logic [OUTCOME_W-1:0] OC_ADD_REJECTED   = 4'd7;
  localparam logic [OUTCOME_W-1:0] OC_WINDOW_CLOSED  = 4'd8;

  // Register map
  localparam logic REG_MODE = 1'b0;

endpackage

`default_nettype wire

FILE: rtl/rwl_table.sv
// Tag table memory with registered read and the shared tag comparator.
`default_nettype none

module rwl_table #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned ID_BITS       = 40,
  parameter int unsigned AW            = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                      clk_i,
  input  wire logic [AW-1:0]             rd_addr_i,
  input  wire logic                      wr_en_i,
  input  wire logic [AW-1:0]             wr_addr_i,
  input  wire logic [rwl_pkg::KIND_W-1:0] key_kind_i,
  input  wire logic [ID_BITS-1:0]        key_id_i,
  output logic                           match_o
);
  import rwl_pkg::*;

  localparam int unsigned EW = KIND_W + ID_BITS;

  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rdata_q;

  // One write and one registered read per cycle; the key is also the write data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {key_kind_i, key_id_i};
    end
    rdata_q <= mem[rd_addr_i];
  end

  // Shared comparator: entry read last cycle against the presented tag
  assign match_o = (rdata_q == {key_kind_i, key_id_i});

endmodule

`default_nettype wire

FILE: rtl/rfid_whitelist_lookup_learn.sv
// An accepted item goes to a search state that compares table entries from slot 0 up to
// the fill count, one entry per cycle, stopping at a hit; timer, spare-action, kind-zero
// and empty-table items skip the search. A decision state then registers the result.
// The input is held off while a search runs or a finished result cannot be registered.
// Reset (rst_ni low, async): table empty by fill count, window closed, mode = button add.
// No clearing pass; the block is ready in the first cycle after reset.
`default_nettype none

module rfid_whitelist_lookup_learn #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned ID_BITS       = 40,
  parameter int unsigned IW            = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB-style configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rwl_pkg::ACTION_W-1:0]  action_i,
  input  wire logic [rwl_pkg::KIND_W-1:0]    tag_kind_i,
  input  wire logic [ID_BITS-1:0]            tag_id_i,
  input  wire logic                          prog_button_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               granted_o,
  output logic [rwl_pkg::OUTCOME_W-1:0]      outcome_o,
  output logic [IW-1:0]                      slot_o,
  output logic                               clear_prog_o
);
  import rwl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] SLOT_NONE = IW'(TABLE_ENTRIES);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                hit_q, hit_d;
  logic [IW-1:0]       cnt_q, cnt_d;
  logic                win_q, win_d;
  logic [MODE_W-1:0]   mode_q;
  logic [ACTION_W-1:0] act_q;
  logic [KIND_W-1:0]   kind_q;
  logic [ID_BITS-1:0]  id_q;
  logic                prog_q;
  logic                out_valid_q;
  logic                granted_q, clear_q;
  logic [OUTCOME_W-1:0] outcome_q;
  logic [IW-1:0]       slot_q;

  logic                in_acc, fire, match, need_search;
  logic                wr_en, st_idx, st0;
  logic [AW-1:0]       wr_addr;
  logic [MODE_W-1:0]   mode_eff;
  logic                res_granted, res_clear;
  logic [OUTCOME_W-1:0] res_outcome;
  logic [IW-1:0]       res_slot, store_slot;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? 32'(mode_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BUTTON;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
      mode_q <= pwdata[MODE_W-1:0];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign need_search = ((action_i == ACT_TAG) || (action_i == ACT_BUS_ADD)) &&
                       (tag_kind_i != '0);
  assign fire        = (state_q == S_DEC) && (!out_valid_q || !out_stall_i);

  // Table and comparator
  rwl_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_BITS       (ID_BITS),
    .AW            (AW)
  ) u_table (
    .clk_i      (clk_i),
    .rd_addr_i  (idx_d[AW-1:0]),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .key_kind_i (kind_q),
    .key_id_i   (id_q),
    .match_o    (match)
  );

  // Search sequencer: one entry compared per cycle up to the fill count
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          hit_d = 1'b0;
          if (need_search && (cnt_q != '0)) begin
            state_d = S_CMP;
          end else begin
            state_d = S_DEC;
          end
        end
      end
      S_CMP: begin
        if (match) begin
          hit_d   = 1'b1;
          state_d = S_DEC;
        end else begin
          idx_d = idx_q + 1'b1;
          if (idx_d == cnt_q) begin
            state_d = S_DEC;
          end
        end
      end
      S_DEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Decision on the search result
  assign mode_eff   = (mode_q == MODE_SPARE) ? MODE_REMOTE : mode_q;
  assign store_slot = (idx_q < SLOT_NONE) ? idx_q : SLOT_NONE;

  always_comb begin
    res_granted = 1'b0;
    res_outcome = OC_DENIED;
    res_slot    = SLOT_NONE;
    res_clear   = 1'b0;
    st_idx      = 1'b0;
    st0         = 1'b0;
    win_d       = win_q;
    unique case (act_q)
      ACT_TAG: begin
        if (kind_q == '0) begin
          win_d     = 1'b0;
          res_clear = 1'b1;
        end else if (hit_q && (idx_q == '0) && (mode_eff == MODE_ADMIN)) begin
          win_d       = 1'b1;
          res_outcome = OC_WINDOW;
          res_slot    = '0;
        end else if (hit_q) begin
          res_granted = 1'b1;
          res_outcome = OC_KNOWN;
          res_slot    = idx_q;
          win_d       = 1'b0;
          res_clear   = 1'b1;
        end else begin
          win_d     = 1'b0;
          res_clear = 1'b1;
          priority if ((idx_q == '0) && (mode_eff != MODE_REMOTE) && !prog_q) begin
            res_granted = 1'b1;
            res_outcome = OC_EMPTY_PASS;
          end else if ((mode_eff == MODE_BUTTON) && prog_q) begin
            st_idx      = 1'b1;
            res_granted = 1'b1;
            res_outcome = OC_LEARNED;
            res_slot    = store_slot;
          end else if ((mode_eff == MODE_ADMIN) && prog_q) begin
            st0         = 1'b1;
            res_outcome = OC_ADMIN_REPLACED;
            res_slot    = '0;
          end else if ((mode_eff == MODE_ADMIN) && win_q) begin
            st_idx      = 1'b1;
            res_granted = 1'b1;
            res_outcome = OC_LEARNED;
            res_slot    = store_slot;
          end else begin
            res_outcome = OC_DENIED;
          end
        end
      end
      ACT_BUS_ADD: begin
        res_outcome = OC_ADD_REJECTED;
        if ((kind_q != '0) && !hit_q && (idx_q < SLOT_NONE)) begin
          st_idx      = 1'b1;
          res_outcome = OC_ADDED;
          res_slot    = idx_q;
        end
      end
      default: begin
        // timer expiry and the spare action code
        win_d       = 1'b0;
        res_outcome = OC_WINDOW_CLOSED;
      end
    endcase
  end

  // Table write: a miss stores at the fill count, admin replace at slot 0
  assign wr_en   = fire && ((st_idx && (idx_q < SLOT_NONE)) || st0);
  assign wr_addr = st0 ? '0 : idx_q[AW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && (!st0 || (cnt_q == '0))) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      cnt_q       <= '0;
      win_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      cnt_q   <= cnt_d;
      if (fire) begin
        win_q <= win_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Captured transaction and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      kind_q <= tag_kind_i;
      id_q   <= tag_id_i;
      prog_q <= prog_button_i;
    end
    if (fire) begin
      granted_q <= res_granted;
      outcome_q <= res_outcome;
      slot_q    <= res_slot;
      clear_q   <= res_clear;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_o    = granted_q;
  assign outcome_o    = outcome_q;
  assign slot_o       = slot_q;
  assign clear_prog_o = clear_q;

endmodule

`default_nettype wire

FILE: rtl/rwl_checker.sv
// Port-level checker for the RFID whitelist block, with its bind.
`default_nettype none
`include "rfid_whitelist_lookup_learn_macros.svh"

module rwl_checker #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned ID_BITS       = 40,
  parameter int unsigned IW            = $clog2(TABLE_ENTRIES + 1)
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         granted_o,
  input wire logic [rwl_pkg::OUTCOME_W-1:0] outcome_o,
  input wire logic [IW-1:0]                slot_o,
  input wire logic                         clear_prog_o
);
  import rwl_pkg::*;

  // A stalled result holds
  `RWL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(outcome_o) && $stable(slot_o) && $stable(granted_o),
    "stalled result changed")

  // One transaction at a time: the input is held off after each acceptance
  `RWL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
    "input accepted while a search is running")

  // Access is granted only for known, learned or empty-table outcomes
  `RWL_ASSERT_NOW(a_grant_outcome, out_valid_o && granted_o,
    (outcome_o == OC_KNOWN) || (outcome_o == OC_LEARNED) || (outcome_o == OC_EMPTY_PASS),
    "grant with a non-grant outcome")

  // Program-mode clear only follows a presented tag that ends the window
  `RWL_ASSERT_NOW(a_clear_outcome, out_valid_o && clear_prog_o,
    (outcome_o != OC_WINDOW) && (outcome_o != OC_ADDED) &&
    (outcome_o != OC_ADD_REJECTED) && (outcome_o != OC_WINDOW_CLOSED),
    "clear request on a bus, timer or window-open result")

  // Admin replacement always rewrites slot 0 and never grants
  `RWL_ASSERT_NOW(a_admin_slot, out_valid_o && (outcome_o == OC_ADMIN_REPLACED),
    (slot_o == '0) && !granted_o,
    "admin replacement outside slot 0")

endmodule

bind rfid_whitelist_lookup_learn rwl_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES),
  .ID_BITS       (ID_BITS),
  .IW            (IW)
) u_rwl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .granted_o    (granted_o),
  .outcome_o    (outcome_o),
  .slot_o       (slot_o),
  .clear_prog_o (clear_prog_o)
);

`default_nettype wire
